### design/nfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nfe_pkg;

   localparam int unsigned MAX_FRAME_ENTRIES = 32;

   localparam int unsigned CFG_W      = 15;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned REPEAT_W   = 8;
   localparam int unsigned HIGH_W     = 16;
   // extent * 1000 stays below 2**25
   localparam int unsigned TIME_W     = 25;
   // a remaining gap at or above 2**24 us does not fit one 0xFFFF run
   localparam int unsigned GAP_LIM_W  = 24;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned BIT_IDX_W  = 5;
   localparam int unsigned RUN_W      = 3;
   localparam int unsigned STEP_W     = 4;
   localparam int unsigned MS_W       = 10;

   localparam logic [MS_W-1:0]     US_PER_MS       = 10'd1000;
   localparam logic [PERIOD_W-1:0] GAP_FULL_PERIOD = 16'hFFFF;
   localparam logic [PERIOD_W-1:0] DUMMY_PERIOD    = 16'd1;

   localparam logic [CFG_W-1:0] RST_LEAD_IN_MARK  = 15'd9000;
   localparam logic [CFG_W-1:0] RST_LEAD_IN_SPACE = 15'd4500;
   localparam logic [CFG_W-1:0] RST_DITTO_SPACE   = 15'd2250;
   localparam logic [CFG_W-1:0] RST_BIT_MARK      = 15'd564;
   localparam logic [CFG_W-1:0] RST_ONE_SPACE     = 15'd1692;
   localparam logic [CFG_W-1:0] RST_ZERO_SPACE    = 15'd564;
   localparam logic [CFG_W-1:0] RST_LEAD_OUT_MARK = 15'd564;
   localparam logic [CFG_W-1:0] RST_EXTENT        = 15'd108;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEAD_IN_MARK  = 3'd0,
      CSR_LEAD_IN_SPACE = 3'd1,
      CSR_DITTO_SPACE   = 3'd2,
      CSR_BIT_MARK      = 3'd3,
      CSR_ONE_SPACE     = 3'd4,
      CSR_ZERO_SPACE    = 3'd5,
      CSR_LEAD_OUT_MARK = 3'd6,
      CSR_EXTENT        = 3'd7
   } csr_idx_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_DUMMY    = 4'd1;
   localparam step_type STEP_LEAD_IN  = 4'd2;
   localparam step_type STEP_BITS     = 4'd3;
   localparam step_type STEP_LEAD_OUT = 4'd4;
   localparam step_type STEP_EXT_MUL  = 4'd5;
   localparam step_type STEP_GAP_SUB  = 4'd6;
   localparam step_type STEP_GAP_HI   = 4'd7;
   localparam step_type STEP_GAP_LO   = 4'd8;
   localparam step_type STEP_PLAY     = 4'd9;
   localparam step_type STEP_DRAIN    = 4'd10;

   typedef enum logic [2:0] {
      ENT_NONE,
      ENT_DUMMY,
      ENT_LEAD_IN,
      ENT_BIT_RUN,
      ENT_LEAD_OUT,
      ENT_GAP_HI,
      ENT_GAP_LO
   } ent_sel_type;

   typedef enum logic [1:0] {
      ALU_NOP,
      ALU_EXT_MUL,
      ALU_GAP_SUB
   } alu_type;

   typedef enum logic [2:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_IDLE,
      JMP_DITTO,
      JMP_NO_EXTENT,
      JMP_BITS_LEFT,
      JMP_PLAY_LEFT
   } jmp_type;

   typedef struct packed {
      ent_sel_type ent_sel;
      alu_type     alu;
      logic        acc_en;
      logic        bit_adv;
      logic        play;
      jmp_type     jmp;
      step_type    target;
   } ucode_type;

   typedef struct packed {
      logic ditto;
      logic no_extent;
      logic bits_left;
   } dp_flags_type;

   typedef struct packed {
      logic ditto;
      logic no_extent;
      logic bits_left;
      logic play_left;
   } cond_type;

   typedef struct packed {
      logic                valid;
      logic [PERIOD_W-1:0] period;
      logic [REPEAT_W-1:0] repeat_cnt;
      logic [HIGH_W-1:0]   high;
   } push_type;

   // control store: one word per step
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      w = '{ent_sel: ENT_NONE, alu: ALU_NOP, acc_en: 1'b0, bit_adv: 1'b0,
            play: 1'b0, jmp: JMP_NEVER, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            w.jmp    = JMP_IDLE;
            w.target = STEP_IDLE;
         end
         STEP_DUMMY: begin
            w.ent_sel = ENT_DUMMY;
         end
         STEP_LEAD_IN: begin
            w.ent_sel = ENT_LEAD_IN;
            w.acc_en  = 1'b1;
            w.jmp     = JMP_DITTO;
            w.target  = STEP_LEAD_OUT;
         end
         STEP_BITS: begin
            w.ent_sel = ENT_BIT_RUN;
            w.acc_en  = 1'b1;
            w.bit_adv = 1'b1;
            w.jmp     = JMP_BITS_LEFT;
            w.target  = STEP_BITS;
         end
         STEP_LEAD_OUT: begin
            w.ent_sel = ENT_LEAD_OUT;
            w.acc_en  = 1'b1;
            w.jmp     = JMP_NO_EXTENT;
            w.target  = STEP_PLAY;
         end
         STEP_EXT_MUL: begin
            w.alu = ALU_EXT_MUL;
         end
         STEP_GAP_SUB: begin
            w.alu = ALU_GAP_SUB;
         end
         STEP_GAP_HI: begin
            w.ent_sel = ENT_GAP_HI;
         end
         STEP_GAP_LO: begin
            w.ent_sel = ENT_GAP_LO;
         end
         STEP_PLAY: begin
            w.play   = 1'b1;
            w.jmp    = JMP_PLAY_LEFT;
            w.target = STEP_PLAY;
         end
         default: begin
            w.jmp    = JMP_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### design/nfe_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module nfe_seq (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  nfe_pkg::cond_type    cond,
   output nfe_pkg::ucode_type   uc,
   output logic                 busy,
   output logic                 accept
);
   import nfe_pkg::*;

   step_type step_ff, step_in;
   logic     jump_taken;

   assign uc     = ucode_rom(step_ff);
   assign busy   = (step_ff != STEP_IDLE);
   assign accept = start && !busy;

   always_comb begin
      unique case (uc.jmp)
         JMP_NEVER:     jump_taken = 1'b0;
         JMP_ALWAYS:    jump_taken = 1'b1;
         JMP_IDLE:      jump_taken = !start;
         JMP_DITTO:     jump_taken = cond.ditto;
         JMP_NO_EXTENT: jump_taken = cond.no_extent;
         JMP_BITS_LEFT: jump_taken = cond.bits_left;
         JMP_PLAY_LEFT: jump_taken = cond.play_left;
         default:       jump_taken = 1'b1;
      endcase
   end

   assign step_in = jump_taken ? uc.target : step_type'(step_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

### design/nfe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module nfe_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  accept,
   input  wire  [nfe_pkg::BYTE_W-1:0]           req_device_byte,
   input  wire  [nfe_pkg::BYTE_W-1:0]           req_subdevice_byte,
   input  wire  [nfe_pkg::BYTE_W-1:0]           req_function_byte,
   input  wire                                  req_ditto,
   input  wire                                  csr_we,
   input  wire  [nfe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [nfe_pkg::CFG_W-1:0]            csr_wdata,
   input  nfe_pkg::ucode_type                   uc,
   output nfe_pkg::dp_flags_type                flags,
   output nfe_pkg::push_type                    push,
   output logic                                 gap_fail
);
   import nfe_pkg::*;

   logic [CFG_W-1:0] lead_in_mark_ff, lead_in_space_ff, ditto_space_ff, bit_mark_ff;
   logic [CFG_W-1:0] one_space_ff, zero_space_ff, lead_out_mark_ff, extent_ff;

   logic [DATA_W-1:0]    data_ff;
   logic                 ditto_ff;
   logic [BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in, bit_nxt;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic [TIME_W-1:0]    total_ff, total_in;
   logic [TIME_W-1:0]    ext_us_ff, ext_us_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [TIME_W:0]      diff;

   logic                 cur_bit, run_end;
   logic [CFG_W-1:0]     head_space;
   logic [PERIOD_W-1:0]  lead_in_period, bit_period, acc_period;
   logic [REPEAT_W-1:0]  gap_upper;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_in_mark_ff  <= RST_LEAD_IN_MARK;
         lead_in_space_ff <= RST_LEAD_IN_SPACE;
         ditto_space_ff   <= RST_DITTO_SPACE;
         bit_mark_ff      <= RST_BIT_MARK;
         one_space_ff     <= RST_ONE_SPACE;
         zero_space_ff    <= RST_ZERO_SPACE;
         lead_out_mark_ff <= RST_LEAD_OUT_MARK;
         extent_ff        <= RST_EXTENT;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LEAD_IN_MARK:  lead_in_mark_ff  <= csr_wdata;
            CSR_LEAD_IN_SPACE: lead_in_space_ff <= csr_wdata;
            CSR_DITTO_SPACE:   ditto_space_ff   <= csr_wdata;
            CSR_BIT_MARK:      bit_mark_ff      <= csr_wdata;
            CSR_ONE_SPACE:     one_space_ff     <= csr_wdata;
            CSR_ZERO_SPACE:    zero_space_ff    <= csr_wdata;
            CSR_LEAD_OUT_MARK: lead_out_mark_ff <= csr_wdata;
            CSR_EXTENT:        extent_ff        <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // bit 0 is the device LSB, so the bytes go out in order, LSB first
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff  <= {~req_function_byte, req_function_byte, req_subdevice_byte,
                      req_device_byte};
         ditto_ff <= req_ditto;
      end
   end

   assign cur_bit = data_ff[bit_idx_ff];
   assign bit_nxt = bit_idx_ff + 1'b1;
   // a run closes at a byte boundary or where the next bit differs
   assign run_end = (bit_idx_ff[RUN_W-1:0] == '1) || (data_ff[bit_nxt] != cur_bit);

   assign head_space     = ditto_ff ? ditto_space_ff : lead_in_space_ff;
   assign lead_in_period = PERIOD_W'(lead_in_mark_ff) + PERIOD_W'(head_space);
   assign bit_period     = PERIOD_W'(bit_mark_ff)
                         + PERIOD_W'(cur_bit ? one_space_ff : zero_space_ff);
   assign gap_upper      = rem_ff[GAP_LIM_W-1:PERIOD_W];

   always_comb begin
      push = '{valid: 1'b0, period: '0, repeat_cnt: '0, high: '0};
      unique case (uc.ent_sel)
         ENT_DUMMY: begin
            push.valid  = 1'b1;
            push.period = DUMMY_PERIOD;
         end
         ENT_LEAD_IN: begin
            push.valid  = 1'b1;
            push.period = lead_in_period;
            push.high   = HIGH_W'(lead_in_mark_ff);
         end
         ENT_BIT_RUN: begin
            push.valid      = run_end;
            push.period     = bit_period;
            push.repeat_cnt = REPEAT_W'(run_ff);
            push.high       = HIGH_W'(bit_mark_ff);
         end
         ENT_LEAD_OUT: begin
            push.valid  = 1'b1;
            push.period = PERIOD_W'(lead_out_mark_ff);
            push.high   = HIGH_W'(lead_out_mark_ff);
         end
         ENT_GAP_HI: begin
            push.valid      = (gap_upper != '0);
            push.period     = GAP_FULL_PERIOD;
            push.repeat_cnt = gap_upper;
         end
         ENT_GAP_LO: begin
            push.valid  = 1'b1;
            push.period = rem_ff[PERIOD_W-1:0];
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (uc.ent_sel)
         ENT_LEAD_IN:  acc_period = lead_in_period;
         ENT_BIT_RUN:  acc_period = bit_period;
         ENT_LEAD_OUT: acc_period = PERIOD_W'(lead_out_mark_ff);
         default:      acc_period = '0;
      endcase
   end

   assign diff = {1'b0, ext_us_ff} - {1'b0, total_ff};

   always_comb begin
      total_in   = total_ff;
      bit_idx_in = bit_idx_ff;
      run_in     = run_ff;
      ext_us_in  = ext_us_ff;
      rem_in     = rem_ff;
      if (accept) begin
         total_in   = '0;
         bit_idx_in = '0;
         run_in     = '0;
      end else begin
         if (uc.acc_en) begin
            total_in = total_ff + TIME_W'(acc_period);
         end
         if (uc.bit_adv) begin
            bit_idx_in = bit_nxt;
            run_in     = run_end ? '0 : RUN_W'(run_ff + 1'b1);
         end
         if (uc.alu == ALU_EXT_MUL) begin
            ext_us_in = TIME_W'(extent_ff) * TIME_W'(US_PER_MS);
         end
         if (uc.alu == ALU_GAP_SUB) begin
            rem_in = diff[TIME_W-1:0];
         end
      end
   end

   // negative gap, or a gap too long for one repeat byte
   assign gap_fail = (uc.alu == ALU_GAP_SUB) && (diff[TIME_W] || diff[GAP_LIM_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         bit_idx_ff <= '0;
         run_ff     <= '0;
      end else begin
         total_ff   <= total_in;
         bit_idx_ff <= bit_idx_in;
         run_ff     <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      ext_us_ff <= ext_us_in;
      rem_ff    <= rem_in;
   end

   assign flags.ditto     = ditto_ff;
   assign flags.no_extent = (extent_ff == '0);
   assign flags.bits_left = (bit_idx_ff != '1);

endmodule

`default_nettype wire

### design/nfe_frame_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module nfe_frame_buf #(
   parameter int unsigned DEPTH = nfe_pkg::MAX_FRAME_ENTRIES
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               clear,
   input  nfe_pkg::push_type                 push,
   input  wire                               fail_set,
   input  wire                               play,
   output logic                              play_left,
   output logic                              rsp_strobe,
   output logic [nfe_pkg::PERIOD_W-1:0]      rsp_period_us,
   output logic [nfe_pkg::REPEAT_W-1:0]      rsp_repeat_count,
   output logic [nfe_pkg::HIGH_W-1:0]        rsp_high_us,
   output logic                              rsp_last,
   output logic                              rsp_error
);
   import nfe_pkg::*;

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   logic [PERIOD_W-1:0] period_mem [DEPTH];
   logic [REPEAT_W-1:0] repeat_mem [DEPTH];
   logic [HIGH_W-1:0]   high_mem   [DEPTH];

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                fail_ff, fail_in;
   logic                strobe_ff, last_ff, err_ff;
   logic [PERIOD_W-1:0] rd_period_ff;
   logic [REPEAT_W-1:0] rd_repeat_ff;
   logic [HIGH_W-1:0]   rd_high_ff;

   logic                live, full, wr_en, at_last;

   // zero-period entries are dropped and take no slot
   assign live    = push.valid && (push.period != '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign wr_en   = live && !full;
   assign at_last = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);

   assign play_left = !fail_ff && !at_last;

   always_comb begin
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      fail_in   = fail_ff;
      if (clear) begin
         count_in  = '0;
         rd_idx_in = '0;
         fail_in   = 1'b0;
      end else begin
         if (wr_en) begin
            count_in = CNT_W'(count_ff + 1'b1);
         end
         if ((live && full) || fail_set) begin
            fail_in = 1'b1;
         end
         if (play) begin
            rd_idx_in = ADDR_W'(rd_idx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_idx_ff <= '0;
         fail_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         fail_ff   <= fail_in;
         strobe_ff <= play;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         period_mem[count_ff[ADDR_W-1:0]] <= push.period;
         repeat_mem[count_ff[ADDR_W-1:0]] <= push.repeat_cnt;
         high_mem[count_ff[ADDR_W-1:0]]   <= push.high;
      end
   end

   always_ff @(posedge clock) begin
      if (play) begin
         rd_period_ff <= period_mem[rd_idx_ff];
         rd_repeat_ff <= repeat_mem[rd_idx_ff];
         rd_high_ff   <= high_mem[rd_idx_ff];
         last_ff      <= fail_ff || at_last;
         err_ff       <= fail_ff;
      end
   end

   // a failed frame sends a single all-zero error beat
   assign rsp_strobe       = strobe_ff;
   assign rsp_period_us    = err_ff ? '0 : rd_period_ff;
   assign rsp_repeat_count = err_ff ? '0 : rd_repeat_ff;
   assign rsp_high_us      = err_ff ? '0 : rd_high_ff;
   assign rsp_last         = last_ff;
   assign rsp_error        = err_ff;

endmodule

`default_nettype wire

### design/ir_nec_frame_pulse_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// NEC IR frame encoder. A command is taken when start is high and busy is low;
// the block then builds the whole frame into an entry buffer and plays it out,
// one entry beat per cycle on rsp_strobe, in back-to-back cycles, rsp_last on
// the final beat. The receiver cannot stall, so it must take a beat every cycle
// the strobe is high. An invalid frame (too many entries, negative gap, or a gap
// of 2**24 us or more) sends one beat with rsp_error and rsp_last set and all
// fields zero. A microcoded sequencer sets the timing: one step per entry source
// and one per data bit; a ditto frame skips the data-bit steps, and a frame with
// extent zero skips the extent and gap steps. Registers are to be written only
// while busy is low; the block itself does not enforce it.
module ir_nec_frame_pulse_encoder #(
   parameter int unsigned MAX_FRAME_ENTRIES = nfe_pkg::MAX_FRAME_ENTRIES
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire  [nfe_pkg::BYTE_W-1:0]           req_device_byte,
   input  wire  [nfe_pkg::BYTE_W-1:0]           req_subdevice_byte,
   input  wire  [nfe_pkg::BYTE_W-1:0]           req_function_byte,
   input  wire                                  req_ditto,
   output logic                                 rsp_strobe,
   output logic [nfe_pkg::PERIOD_W-1:0]         rsp_period_us,
   output logic [nfe_pkg::REPEAT_W-1:0]         rsp_repeat_count,
   output logic [nfe_pkg::HIGH_W-1:0]           rsp_high_us,
   output logic                                 rsp_last,
   output logic                                 rsp_error,
   input  wire                                  csr_we,
   input  wire  [nfe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [nfe_pkg::CFG_W-1:0]            csr_wdata
);
   import nfe_pkg::*;

   ucode_type    uc;
   cond_type     cond;
   dp_flags_type flags;
   push_type     push;
   logic         accept;
   logic         gap_fail;
   logic         play_left;

   assign cond.ditto     = flags.ditto;
   assign cond.no_extent = flags.no_extent;
   assign cond.bits_left = flags.bits_left;
   assign cond.play_left = play_left;

   nfe_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cond   (cond),
      .uc     (uc),
      .busy   (busy),
      .accept (accept)
   );

   nfe_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .req_device_byte    (req_device_byte),
      .req_subdevice_byte (req_subdevice_byte),
      .req_function_byte  (req_function_byte),
      .req_ditto          (req_ditto),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .uc                 (uc),
      .flags              (flags),
      .push               (push),
      .gap_fail           (gap_fail)
   );

   nfe_frame_buf #(
      .DEPTH (MAX_FRAME_ENTRIES)
   ) u_frame_buf (
      .clock            (clock),
      .reset            (reset),
      .clear            (accept),
      .push             (push),
      .fail_set         (gap_fail),
      .play             (uc.play),
      .play_left        (play_left),
      .rsp_strobe       (rsp_strobe),
      .rsp_period_us    (rsp_period_us),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_high_us      (rsp_high_us),
      .rsp_last         (rsp_last),
      .rsp_error        (rsp_error)
   );

endmodule

`default_nettype wire
